// ===== design/hrsu_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP response header scanner - shared definitions
// Request operation codes, finish codes, byte constants and the status
// struct that passes between the header scanner and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package hrsu_pkg;

  // Default counter width for the length and body counters
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_FIELD_W = 1 + 1 + 32 + 32 + 2;
  localparam int unsigned OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_FIELD_W;

  // Operation carried in tuser of an input request
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_START = 2'd1,
    OP_CLOSE = 2'd2
  } op_e;

  // Finish status of the current response
  typedef enum logic [1:0] {
    FIN_RUN    = 2'd0,
    FIN_LENGTH = 2'd1,
    FIN_CLOSED = 2'd2
  } fin_e;

  // Byte values the scanner reacts to
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  // Header scanner status
  typedef struct packed {
    logic in_body;
    logic len_valid;
  } hdr_status_t;

endpackage

`default_nettype wire

// ===== design/http_response_header_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// HTTP response header scanner - top level
// Scans an HTTP response byte stream for Content-Length, finds the start of
// the body, counts body bytes and reports when the response has finished.
// ----------------------------------------------------------------------------
// Output: a status item is registered and appears on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle while the master side is not stalled; all scanning and
//   counting for a byte is combinational between the scan registers and the output register.
// s_axis_tready_o is high whenever the output register is empty or drained in the same cycle.
// Reset: rst_ni (async, active low) returns to line start with no length, zero body
//   count and no finish; a start request does the same.
`default_nettype none

module http_response_header_scanner_unit #(
  parameter int unsigned COUNT_WIDTH = hrsu_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input requests
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [hrsu_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic [hrsu_pkg::IN_USER_W-1:0]  s_axis_tuser_i,  // [1:0] operation
  // Status results
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [0] in_body, [1] length_known, [33:2] length_value, [65:34] body_count,
  // [67:66] finish, [71:68] zero
  output logic [hrsu_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  // Handshake
  logic accept;
  logic is_byte, is_start, is_close;

  // Scanner interface
  hrsu_pkg::hdr_status_t  hdr_q, hdr_d;
  logic [COUNT_WIDTH-1:0] len_q, len_d;
  logic                   scan_step;

  // Body counter and finish status
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  hrsu_pkg::fin_e         fin_q, fin_d;

  // Output register
  logic                              out_valid_q;
  logic [hrsu_pkg::OUT_DATA_W-1:0]   out_data_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign is_byte  = (s_axis_tuser_i == hrsu_pkg::OP_BYTE);
  assign is_start = (s_axis_tuser_i == hrsu_pkg::OP_START);
  assign is_close = (s_axis_tuser_i == hrsu_pkg::OP_CLOSE);

  // Header bytes go to the line machine only while running and not yet in body
  assign scan_step = accept && is_byte && (fin_q == hrsu_pkg::FIN_RUN) && !hdr_q.in_body;

  hrsu_header_scan #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (accept && is_start),
    .step_i     (scan_step),
    .byte_i     (s_axis_tdata_i),
    .status_o   (hdr_q),
    .status_d_o (hdr_d),
    .length_o   (len_q),
    .length_d_o (len_d)
  );

  // Body byte counting and finish detection. The byte that ends the header
  // is not a body byte; the finish test follows each counted body byte.
  assign cnt_inc = (cnt_q == CountMax) ? cnt_q : (cnt_q + COUNT_WIDTH'(1));

  always_comb begin
    cnt_d = cnt_q;
    fin_d = fin_q;
    if (accept) begin
      priority if (is_start) begin
        cnt_d = '0;
        fin_d = hrsu_pkg::FIN_RUN;
      end else if (is_close) begin
        if (fin_q == hrsu_pkg::FIN_RUN) begin
          fin_d = hrsu_pkg::FIN_CLOSED;
        end
      end else if (is_byte && (fin_q == hrsu_pkg::FIN_RUN) && hdr_q.in_body) begin
        cnt_d = cnt_inc;
        if (hdr_q.len_valid && (cnt_inc >= len_q)) begin
          fin_d = hrsu_pkg::FIN_LENGTH;
        end
      end else begin
        // reserved operation, header byte or byte after finish: nothing changes
        cnt_d = cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fin_q       <= hrsu_pkg::FIN_RUN;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      fin_q <= fin_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status payload: state after the request, counters shown as low 32 bits
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {{hrsu_pkg::OUT_PAD_W{1'b0}},
                     fin_d,
                     32'(cnt_d),
                     32'(len_d),
                     hdr_d.len_valid,
                     hdr_d.in_body};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// ===== design/hrsu_header_scan.sv =====
// ----------------------------------------------------------------------------
// HTTP response header scanner - header line machine
// Tracks line starts, matches "content-length:" in any letter case, skips
// blanks, accumulates the decimal length and detects the blank line that
// opens the body. Holds the scan state and the length register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrsu_header_scan #(
  parameter int unsigned COUNT_WIDTH = hrsu_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clear_i,    // start of a new response
  input  wire logic                     step_i,     // header byte to scan
  input  wire logic [7:0]               byte_i,
  output hrsu_pkg::hdr_status_t         status_o,   // current status
  output hrsu_pkg::hdr_status_t         status_d_o, // status after this cycle
  output logic      [COUNT_WIDTH-1:0]   length_o,
  output logic      [COUNT_WIDTH-1:0]   length_d_o
);

  typedef enum logic [4:0] {
    SC_BOL     = 5'd0,
    SC_TEXT    = 5'd1,
    SC_LF      = 5'd2,
    SC_CR      = 5'd3,
    SC_CRLF    = 5'd4,
    SC_CRLFCR  = 5'd5,
    SC_MATCH1  = 5'd6,
    SC_MATCH2  = 5'd7,
    SC_MATCH3  = 5'd8,
    SC_MATCH4  = 5'd9,
    SC_MATCH5  = 5'd10,
    SC_MATCH6  = 5'd11,
    SC_MATCH7  = 5'd12,
    SC_MATCH8  = 5'd13,
    SC_MATCH9  = 5'd14,
    SC_MATCH10 = 5'd15,
    SC_MATCH11 = 5'd16,
    SC_MATCH12 = 5'd17,
    SC_MATCH13 = 5'd18,
    SC_MATCH14 = 5'd19,
    SC_COLON   = 5'd20,
    SC_SPACE   = 5'd21,
    SC_DIGITS  = 5'd22,
    SC_BODY    = 5'd23
  } scan_e;

  // Header name, lower case; element 0 holds the first letter
  localparam logic [13:0][7:0] HdrName = "htgnel-tnetnoc";

  scan_e                  state_q, state_d;
  logic [COUNT_WIDTH-1:0] len_q, len_d;
  logic                   lv_q, lv_d;

  logic [7:0]             lc;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [3:0]             match_idx;
  logic                   line_start;
  logic [COUNT_WIDTH+3:0] len_x10;

  always_comb begin
    lc         = ((byte_i >= hrsu_pkg::CH_UP_A) && (byte_i <= hrsu_pkg::CH_UP_Z)) ?
                 (byte_i | 8'h20) : byte_i;
    is_digit   = (byte_i >= hrsu_pkg::CH_ZERO) && (byte_i <= hrsu_pkg::CH_NINE);
    digit      = 4'(byte_i - hrsu_pkg::CH_ZERO);
    // next letter to match: state MATCHn expects letter n (0-based)
    match_idx  = 4'(state_q - SC_MATCH1) + 4'd1;
    line_start = (state_q == SC_BOL) || (state_q == SC_LF) || (state_q == SC_CR) ||
                 (state_q == SC_CRLF) || (state_q == SC_CRLFCR);
    // len*10 + digit; any bit at or above bit COUNT_WIDTH means saturation
    len_x10    = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} +
                 {{COUNT_WIDTH{1'b0}}, digit};
  end

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    lv_d    = lv_q;
    if (step_i) begin
      priority if (line_start) begin
        priority if (byte_i == hrsu_pkg::CH_LF) begin
          if (state_q == SC_BOL) begin
            state_d = SC_LF;
          end else if (state_q == SC_CR) begin
            state_d = SC_CRLF;
          end else begin
            state_d = SC_BODY;
          end
        end else if (byte_i == hrsu_pkg::CH_CR) begin
          if ((state_q == SC_BOL) || (state_q == SC_LF)) begin
            state_d = SC_CR;
          end else if (state_q == SC_CRLF) begin
            state_d = SC_CRLFCR;
          end else begin
            state_d = SC_BODY;
          end
        end else if (lc == HdrName[0]) begin
          state_d = SC_MATCH1;
        end else begin
          state_d = SC_TEXT;
        end
      end else if (state_q == SC_BODY) begin
        state_d = SC_BODY;
      end else if ((state_q >= SC_MATCH1) && (state_q < SC_MATCH14) &&
                   (lc == HdrName[match_idx])) begin
        state_d = scan_e'(state_q + 5'd1);
      end else if ((state_q == SC_MATCH14) && (byte_i == hrsu_pkg::CH_COLON)) begin
        state_d = SC_COLON;
      end else if (((state_q == SC_COLON) || (state_q == SC_SPACE)) &&
                   ((byte_i == hrsu_pkg::CH_SPACE) || (byte_i == hrsu_pkg::CH_TAB))) begin
        state_d = SC_SPACE;
      end else if (is_digit && (state_q == SC_SPACE)) begin
        // first digit replaces any earlier length
        len_d   = COUNT_WIDTH'(digit);
        lv_d    = 1'b1;
        state_d = SC_DIGITS;
      end else if (is_digit && (state_q == SC_DIGITS)) begin
        len_d = (len_x10[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0) ?
                {COUNT_WIDTH{1'b1}} : len_x10[COUNT_WIDTH-1:0];
      end else if (byte_i == hrsu_pkg::CH_LF) begin
        state_d = SC_LF;
      end else if (byte_i == hrsu_pkg::CH_CR) begin
        state_d = SC_CR;
      end else begin
        state_d = SC_TEXT;
      end
    end
    if (clear_i) begin
      state_d = SC_BOL;
      len_d   = '0;
      lv_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_BOL;
      len_q   <= '0;
      lv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      lv_q    <= lv_d;
    end
  end

  assign status_o.in_body     = (state_q == SC_BODY);
  assign status_o.len_valid   = lv_q;
  assign status_d_o.in_body   = (state_d == SC_BODY);
  assign status_d_o.len_valid = lv_d;
  assign length_o             = len_q;
  assign length_d_o           = len_d;

endmodule

`default_nettype wire
